// ===== sv/servo_slew_and_sweep_core_macros.svh =====
// ---------------------------------------------------------------------------
// Servo slew and sweep core assertion macros
// Shared assertion forms used by the servo slew and sweep core.
// ---------------------------------------------------------------------------
`ifndef SERVO_SLEW_AND_SWEEP_CORE_MACROS_SVH
`define SERVO_SLEW_AND_SWEEP_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ssw_pkg.sv =====
// ---------------------------------------------------------------------------
// Servo slew and sweep package
// Types, register indexes and angle constants shared by the core.
// ---------------------------------------------------------------------------
`default_nettype none

package ssw_pkg;

  localparam int unsigned ANGLE_W  = 11;
  localparam int unsigned TARGET_W = 13;
  localparam int unsigned PULSE_W  = 12;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  localparam logic [ANGLE_W-1:0] GOAL_MAX    = 11'd1200;
  localparam logic [ANGLE_W-1:0] ANGLE_FULL  = 11'd1800;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET = 11'd900;
  localparam logic [PULSE_W-1:0] PULSE_BASE  = 12'd500;
  localparam logic [PULSE_W-1:0] PULSE_TOP   = 12'd2500;
  // angle * 2000 / 1800 equals (angle * 72820) >> 16 for every angle up to 1800.
  localparam logic [16:0]        PULSE_RECIP = 17'd72820;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 8'd10;
  localparam logic [ANGLE_W-1:0] LEFT_RESET  = 11'd300;
  localparam logic [ANGLE_W-1:0] RIGHT_RESET = 11'd1500;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_SWEEP_MODE  = 2'd0,
    REG_STEP_SIZE   = 2'd1,
    REG_LEFT_LIMIT  = 2'd2,
    REG_RIGHT_LIMIT = 2'd3
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== sv/ssw_cmd_if.sv =====
// ---------------------------------------------------------------------------
// Servo command channel
// Valid/ready channel carrying tick and set-target words into the core.
// ---------------------------------------------------------------------------
`default_nettype none

interface ssw_cmd_if;
  import ssw_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic signed [TARGET_W-1:0] target_angle;

  modport source (output valid, output operation, output target_angle, input ready);
  modport sink (input valid, input operation, input target_angle, output ready);
endinterface

`default_nettype wire

// ===== sv/ssw_res_if.sv =====
// ---------------------------------------------------------------------------
// Servo result channel
// Valid/ready channel carrying pulse width and angle words out of the core.
// ---------------------------------------------------------------------------
`default_nettype none

interface ssw_res_if;
  import ssw_pkg::*;

  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_width_us;
  logic [ANGLE_W-1:0] current_angle;

  modport source (output valid, output pulse_width_us, output current_angle, input ready);
  modport sink (input valid, input pulse_width_us, input current_angle, output ready);
endinterface

`default_nettype wire

// ===== sv/servo_slew_and_sweep_core.sv =====
// ---------------------------------------------------------------------------
// Servo slew and sweep core
// Moves a servo angle toward a target or between two limits, one step per
// tick, and reports the matching pulse width.
// ---------------------------------------------------------------------------
// Command words enter on cmd: a tick, or a set-target that clamps the target
// to 0..120.0 degrees and enables motion. Set-target words give no result.
// Each tick while motion is enabled gives one word on res with the pulse
// width in microseconds and the new angle; other ticks give nothing.
// A command word is registered, then updated against the angle state and
// written to the result register once the result register is free or taken.
// One word is accepted every cycle while res is not stalled; the angle state
// loop is closed, so each update sees the state left by the word before.
// When res is stalled with a word waiting, a full command register holds and
// cmd.ready drops until the result is taken.
// The APB port writes sweep_mode, step_size, left_limit and right_limit; the
// user must do so only while the core is idle, which the core does not check.
// Synchronous reset empties both registers, sets the angle and the target to
// 90.0 degrees, stops motion, heads the sweep right, loads register defaults.
`default_nettype none

module servo_slew_and_sweep_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  ssw_cmd_if.sink                        cmd,
  ssw_res_if.source                      res,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ssw_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssw_pkg::DATA_W-1:0] pwdata,
  output logic      [ssw_pkg::DATA_W-1:0] prdata,
  output logic                           pready
);
  import ssw_pkg::*;
  `include "servo_slew_and_sweep_core_macros.svh"

  logic               sweep_mode;
  logic [STEP_W-1:0]  step_size;
  logic [ANGLE_W-1:0] left_limit;
  logic [ANGLE_W-1:0] right_limit;

  logic                       s1_valid;
  op_t                        s1_op;
  logic signed [TARGET_W-1:0] s1_target;
  logic                       s1_adv;
  logic                       fire;

  logic [ANGLE_W-1:0] angle_now;
  logic [ANGLE_W-1:0] angle_now_next;
  logic [ANGLE_W-1:0] angle_goal;
  logic [ANGLE_W-1:0] angle_goal_next;
  logic               moving;
  logic               moving_next;
  logic               heading_right;
  logic               heading_right_next;
  logic               emit;

  logic                 res_valid;
  logic [PULSE_W-1:0]   res_pulse;
  logic [ANGLE_W-1:0]   res_angle;

  logic [ANGLE_W-1:0]         lo;
  logic [ANGLE_W-1:0]         hi;
  logic [ANGLE_W:0]           up;
  logic signed [ANGLE_W+1:0]  dn;
  logic [ANGLE_W-1:0]         goal_clamped;
  logic [27:0]                pulse_prod;
  logic                       cfg_wr;
  reg_idx_t                   cfg_idx;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_mode  <= 1'b0;
      step_size   <= STEP_RESET;
      left_limit  <= LEFT_RESET;
      right_limit <= RIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SWEEP_MODE:  sweep_mode  <= pwdata[0];
        REG_STEP_SIZE:   step_size   <= pwdata[STEP_W-1:0];
        REG_LEFT_LIMIT:  left_limit  <= pwdata[ANGLE_W-1:0];
        REG_RIGHT_LIMIT: right_limit <= pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SWEEP_MODE:  prdata = {{(DATA_W-1){1'b0}}, sweep_mode};
      REG_STEP_SIZE:   prdata = {{(DATA_W-STEP_W){1'b0}}, step_size};
      REG_LEFT_LIMIT:  prdata = {{(DATA_W-ANGLE_W){1'b0}}, left_limit};
      REG_RIGHT_LIMIT: prdata = {{(DATA_W-ANGLE_W){1'b0}}, right_limit};
      default:         prdata = '0;
    endcase
  end

  // Command register.
  assign s1_adv    = !res_valid || res.ready;
  assign cmd.ready = !s1_valid || s1_adv;
  assign fire      = s1_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1_op     <= op_t'(cmd.operation);
      s1_target <= cmd.target_angle;
    end
  end

  // Angle update.
  assign lo = (left_limit > ANGLE_FULL) ? ANGLE_FULL : left_limit;
  assign hi = (right_limit > ANGLE_FULL) ? ANGLE_FULL : right_limit;
  assign up = {1'b0, angle_now} + {{(ANGLE_W+1-STEP_W){1'b0}}, step_size};
  assign dn = $signed({2'b00, angle_now}) - $signed({{(ANGLE_W+2-STEP_W){1'b0}}, step_size});

  always_comb begin
    if (s1_target < 0) begin
      goal_clamped = '0;
    end else if (s1_target > $signed({2'b00, GOAL_MAX})) begin
      goal_clamped = GOAL_MAX;
    end else begin
      goal_clamped = s1_target[ANGLE_W-1:0];
    end
  end

  always_comb begin
    angle_now_next     = angle_now;
    angle_goal_next    = angle_goal;
    moving_next        = moving;
    heading_right_next = heading_right;
    emit               = 1'b0;
    if (s1_op == OP_SET) begin
      angle_goal_next = goal_clamped;
      moving_next     = 1'b1;
    end else if (moving) begin
      emit = 1'b1;
      if (sweep_mode) begin
        if (heading_right) begin
          if (up >= {1'b0, hi}) begin
            angle_now_next     = hi;
            heading_right_next = 1'b0;
          end else begin
            angle_now_next = up[ANGLE_W-1:0];
          end
        end else begin
          if (dn <= $signed({2'b00, lo})) begin
            angle_now_next     = lo;
            heading_right_next = 1'b1;
          end else begin
            angle_now_next = dn[ANGLE_W-1:0];
          end
        end
      end else begin
        if (angle_now < angle_goal) begin
          angle_now_next = (up > {1'b0, angle_goal}) ? angle_goal : up[ANGLE_W-1:0];
        end else if (angle_now > angle_goal) begin
          angle_now_next = (dn < $signed({2'b00, angle_goal})) ? angle_goal
                                                                : dn[ANGLE_W-1:0];
        end
        moving_next = (angle_now_next != angle_goal);
      end
    end
  end

  assign pulse_prod = {{(28-ANGLE_W){1'b0}}, angle_now_next} * {11'd0, PULSE_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_now     <= ANGLE_RESET;
      angle_goal    <= ANGLE_RESET;
      moving        <= 1'b0;
      heading_right <= 1'b1;
    end else if (fire) begin
      angle_now     <= angle_now_next;
      angle_goal    <= angle_goal_next;
      moving        <= moving_next;
      heading_right <= heading_right_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res_pulse <= pulse_prod[27:16] + PULSE_BASE;
      res_angle <= angle_now_next;
    end
  end

  assign res.valid          = res_valid;
  assign res.pulse_width_us = res_pulse;
  assign res.current_angle  = res_angle;

  `SSW_ASSERT_NEXT(a_set_enables, fire && (s1_op == OP_SET), moving, "set target did not enable motion")
  `SSW_ASSERT_NOW(a_ready_stall, !cmd.ready, res_valid && !res.ready, "command stalled without output backpressure")
  `SSW_ASSERT_NOW(a_pulse_range, res_valid, (res_pulse >= PULSE_BASE) && (res_pulse <= PULSE_TOP), "pulse width out of range")
  `SSW_ASSERT_NOW(a_angle_range, 1'b1, (angle_now <= ANGLE_FULL) && (angle_goal <= GOAL_MAX), "angle state out of range")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Servo slew and sweep core testbench
// Drives tick and set-target words into the core through directed cases,
// random slew and sweep phases, a long result stall and an unbroken stream.
// Every result word is checked against a local model of the angle state.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssw_pkg::*;

  typedef struct {
    logic [PULSE_W-1:0] pulse;
    logic [ANGLE_W-1:0] angle;
  } servo_word_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  ssw_cmd_if cmd_ch ();
  ssw_res_if res_ch ();

  servo_slew_and_sweep_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic               cfg_sweep_mode;
  logic [STEP_W-1:0]  cfg_step;
  logic [ANGLE_W-1:0] cfg_left;
  logic [ANGLE_W-1:0] cfg_right;

  logic [ANGLE_W-1:0] servo_angle;
  logic [ANGLE_W-1:0] servo_goal;
  logic               servo_moving;
  logic               sweep_right;

  servo_word_t pending_pulses[$];
  int unsigned error_count = 0;
  int unsigned hold_left = 0;
  bit          idle_on = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 100) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic void advance_servo(input op_t op, input logic signed [TARGET_W-1:0] tgt);
    int a;
    int lo;
    int hi;
    int g;
    servo_word_t w;
    if (op == OP_SET) begin
      g = tgt;
      if (g < 0) g = 0;
      if (g > int'(GOAL_MAX)) g = int'(GOAL_MAX);
      servo_goal = ANGLE_W'(g);
      servo_moving = 1'b1;
      return;
    end
    if (!servo_moving) return;
    a = int'(servo_angle);
    g = int'(servo_goal);
    if (cfg_sweep_mode) begin
      lo = (cfg_left > ANGLE_FULL) ? int'(ANGLE_FULL) : int'(cfg_left);
      hi = (cfg_right > ANGLE_FULL) ? int'(ANGLE_FULL) : int'(cfg_right);
      if (sweep_right) begin
        a = a + int'(cfg_step);
        if (a >= hi) begin
          a = hi;
          sweep_right = 1'b0;
        end
      end else begin
        a = a - int'(cfg_step);
        if (a <= lo) begin
          a = lo;
          sweep_right = 1'b1;
        end
      end
    end else begin
      if (a < g) begin
        a = a + int'(cfg_step);
        if (a > g) a = g;
      end else if (a > g) begin
        a = a - int'(cfg_step);
        if (a < g) a = g;
      end
      if (a == g) servo_moving = 1'b0;
    end
    servo_angle = ANGLE_W'(a);
    w.angle = servo_angle;
    w.pulse = PULSE_W'(a * (int'(PULSE_TOP) - int'(PULSE_BASE)) / int'(ANGLE_FULL)
                       + int'(PULSE_BASE));
    pending_pulses.push_back(w);
  endfunction

  function automatic logic signed [TARGET_W-1:0] pick_target();
    int v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 8191) - 4096;
      1: v = 0;
      2: v = int'(GOAL_MAX);
      3: v = -int'($urandom_range(1, 60));
      default: v = $urandom_range(0, 1300);
    endcase
    return TARGET_W'(v);
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_limit();
    if ($urandom_range(0, 7) == 0) return ANGLE_W'($urandom_range(1801, 2047));
    return ANGLE_W'($urandom_range(0, 1800));
  endfunction

  task automatic send_word(input op_t op, input logic signed [TARGET_W-1:0] tgt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.operation    <= op;
    cmd_ch.target_angle <= tgt;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    advance_servo(op, tgt);
  endtask

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SWEEP_MODE:  cfg_sweep_mode = value[0];
      REG_STEP_SIZE:   cfg_step = value[STEP_W-1:0];
      REG_LEFT_LIMIT:  cfg_left = value[ANGLE_W-1:0];
      REG_RIGHT_LIMIT: cfg_right = value[ANGLE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_reg(input reg_idx_t idx, input logic [DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      report_mismatch($sformatf("register %s read %0d, expected %0d", idx.name(), prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic mode, input logic [STEP_W-1:0] step,
                                input logic [ANGLE_W-1:0] left,
                                input logic [ANGLE_W-1:0] right);
    logic [DATA_W-1:0] noise;
    noise = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom()) : '0;
    write_reg(REG_SWEEP_MODE, {noise[DATA_W-1:1], mode});
    write_reg(REG_STEP_SIZE, {noise[DATA_W-1:STEP_W], step});
    write_reg(REG_LEFT_LIMIT, {noise[DATA_W-1:ANGLE_W], left});
    write_reg(REG_RIGHT_LIMIT, {noise[DATA_W-1:ANGLE_W], right});
  endtask

  task automatic test_register_access();
    check_reg(REG_SWEEP_MODE, 32'd0);
    check_reg(REG_STEP_SIZE, 32'(STEP_RESET));
    check_reg(REG_LEFT_LIMIT, 32'(LEFT_RESET));
    check_reg(REG_RIGHT_LIMIT, 32'(RIGHT_RESET));
    apply_settings(1'b1, 8'hA5, 11'h7FF, 11'h555);
    check_reg(REG_SWEEP_MODE, 32'd1);
    check_reg(REG_STEP_SIZE, 32'hA5);
    check_reg(REG_LEFT_LIMIT, 32'h7FF);
    check_reg(REG_RIGHT_LIMIT, 32'h555);
    apply_settings(1'b0, STEP_RESET, LEFT_RESET, RIGHT_RESET);
  endtask

  task automatic test_directed_slew();
    send_word(OP_TICK, 13'sd0);
    send_word(OP_SET, 13'sd4095);
    send_word(OP_TICK, 13'sd0);
    send_word(OP_TICK, -13'sd1);
    send_word(OP_SET, -13'sd4096);
    send_word(OP_TICK, 13'sd0);
    send_word(OP_SET, 13'sd915);
    send_word(OP_TICK, 13'sd0);
    send_word(OP_TICK, 13'sd0);
  endtask

  task automatic test_directed_zero_step();
    settle();
    apply_settings(1'b0, 8'd0, LEFT_RESET, RIGHT_RESET);
    send_word(OP_SET, 13'sd915);
    send_word(OP_TICK, 13'sd0);
    send_word(OP_TICK, 13'sd0);
    send_word(OP_SET, 13'sd1200);
    send_word(OP_TICK, 13'sd0);
    settle();
    apply_settings(1'b0, 8'd255, LEFT_RESET, RIGHT_RESET);
    send_word(OP_TICK, 13'sd0);
    send_word(OP_TICK, 13'sd0);
  endtask

  task automatic test_directed_sweep();
    settle();
    apply_settings(1'b1, 8'd255, 11'd2047, 11'd2047);
    send_word(OP_TICK, 13'sd0);
    send_word(OP_SET, -13'sd1);
    send_word(OP_TICK, 13'sd0);
    send_word(OP_TICK, 13'sd0);
    send_word(OP_TICK, 13'sd0);
    send_word(OP_TICK, 13'sd0);
    settle();
    apply_settings(1'b1, 8'd255, 11'd0, 11'd100);
    send_word(OP_TICK, 13'sd0);
    send_word(OP_TICK, 13'sd0);
  endtask

  task automatic test_random_slew(input int unsigned phases, input int unsigned count);
    int unsigned sent;
    int unsigned ticks;
    int gap;
    logic [STEP_W-1:0] step;
    for (int unsigned p = 0; p < phases; p++) begin
      settle();
      case (p)
        0: step = 8'd1;
        1: step = 8'd255;
        2: step = 8'd0;
        default: step = ($urandom_range(0, 3) == 0) ? STEP_W'($urandom_range(0, 255))
                                                    : STEP_W'($urandom_range(1, 40));
      endcase
      apply_settings(1'b0, step, pick_limit(), pick_limit());
      idle_on = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < count) begin
        if ($urandom_range(0, 7) == 0) begin
          send_word(op_t'($urandom_range(0, 1)), TARGET_W'($urandom()));
          sent++;
        end else begin
          send_word(OP_SET, pick_target());
          sent++;
          gap = int'(servo_goal) - int'(servo_angle);
          if (gap < 0) gap = -gap;
          if (cfg_step == 0) ticks = $urandom_range(1, 5);
          else ticks = gap / int'(cfg_step) + $urandom_range(0, 3);
          if (ticks > 60) ticks = 60;
          if (ticks == 0) ticks = 1;
          repeat (ticks) begin
            send_word(OP_TICK, TARGET_W'($urandom()));
            sent++;
          end
        end
      end
    end
  endtask

  task automatic test_random_sweep(input int unsigned phases, input int unsigned count);
    int unsigned sent;
    for (int unsigned p = 0; p < phases; p++) begin
      settle();
      case (p)
        0: apply_settings(1'b1, 8'd255, 11'd0, 11'd1800);
        1: apply_settings(1'b1, 8'd1, 11'd2047, 11'd0);
        2: apply_settings(1'b1, 8'd0, 11'd1800, 11'd2047);
        default: apply_settings(1'b1, STEP_W'($urandom_range(0, 255)), pick_limit(),
                                pick_limit());
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      send_word(OP_SET, pick_target());
      sent = 1;
      while (sent < count) begin
        if ($urandom_range(0, 15) == 0) send_word(OP_SET, pick_target());
        else send_word(OP_TICK, TARGET_W'($urandom()));
        sent++;
      end
    end
  endtask

  task automatic test_result_backpressure();
    settle();
    idle_on = 1'b0;
    apply_settings(1'b1, 8'd7, 11'd0, 11'd1800);
    send_word(OP_SET, 13'sd600);
    hold_left = 80;
    repeat (40) send_word(OP_TICK, TARGET_W'($urandom()));
    settle();
  endtask

  task automatic test_unbroken_stream();
    settle();
    idle_on = 1'b0;
    apply_settings(1'($urandom_range(0, 1)), STEP_W'($urandom_range(1, 30)), pick_limit(),
                   pick_limit());
    send_word(OP_SET, pick_target());
    repeat (120) begin
      if ($urandom_range(0, 9) == 0) send_word(OP_SET, pick_target());
      else send_word(OP_TICK, TARGET_W'($urandom()));
    end
  endtask

  initial begin : result_stall
    int unsigned burst_left;
    burst_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        res_ch.ready <= 1'b0;
        burst_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        res_ch.ready <= 1'b0;
        burst_left = $urandom_range(0, 12);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    servo_word_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_pulses.size() == 0) begin
        report_mismatch($sformatf("unexpected word, angle %0d", res_ch.current_angle));
      end else begin
        w = pending_pulses.pop_front();
        if (res_ch.pulse_width_us !== w.pulse) begin
          report_mismatch($sformatf("pulse_width_us %0d, expected %0d",
                                    res_ch.pulse_width_us, w.pulse));
        end
        if (res_ch.current_angle !== w.angle) begin
          report_mismatch($sformatf("current_angle %0d, expected %0d",
                                    res_ch.current_angle, w.angle));
        end
      end
    end
  end

  initial begin : run_limit
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : main_sequence
    rst                 <= 1'b1;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.operation    <= OP_TICK;
    cmd_ch.target_angle <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    cfg_sweep_mode = 1'b0;
    cfg_step       = STEP_RESET;
    cfg_left       = LEFT_RESET;
    cfg_right      = RIGHT_RESET;
    servo_angle    = ANGLE_RESET;
    servo_goal     = ANGLE_RESET;
    servo_moving   = 1'b0;
    sweep_right    = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_directed_slew();
    test_directed_zero_step();
    test_directed_sweep();
    test_random_slew(6, 140);
    test_random_sweep(6, 140);
    test_result_backpressure();
    test_unbroken_stream();
    settle();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/ssw_pkg.sv
sv/ssw_cmd_if.sv
sv/ssw_res_if.sv
sv/servo_slew_and_sweep_core.sv
tb/testbench.sv
